/* rtl/dsc_pkg.sv */
// Shared types and constants for the Diophantine solution counter.
`default_nettype none
package dsc_pkg;

    localparam int OPERAND_WIDTH = 32;   // default significant bits of each input field
    localparam int FIELD_W       = 32;   // width of every input field and of the gcd
    localparam int RES_W         = 64;   // width of particular solutions and count
    localparam int K_W           = 66;   // signed width for offsets and k bounds
    localparam int PROD_MAX_W    = 68;   // product width at the widest operand setting

    typedef struct packed {
        logic signed [FIELD_W-1:0] a_coef;
        logic signed [FIELD_W-1:0] b_coef;
        logic signed [FIELD_W-1:0] c_rhs;
        logic signed [FIELD_W-1:0] x_lower;
        logic signed [FIELD_W-1:0] x_upper;
        logic signed [FIELD_W-1:0] y_lower;
        logic signed [FIELD_W-1:0] y_upper;
    } in_item_t;

    typedef struct packed {
        logic                     solvable;
        logic signed [RES_W-1:0]  x_particular;
        logic signed [RES_W-1:0]  y_particular;
        logic [FIELD_W-1:0]       gcd_value;
        logic [RES_W-1:0]         solution_count;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic short_op;
    } div_ctl_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EUC,
        S_EUC_WAIT,
        S_EUC_MS,
        S_EUC_US,
        S_EUC_UT,
        S_CDIV,
        S_CDIV_WAIT,
        S_X0M,
        S_X0,
        S_Y0,
        S_K,
        S_K_WAIT,
        S_KCNT,
        S_ZMUL,
        S_ZSAT,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

/* rtl/dsc_stream_if.sv */
// Valid/ready stream channel carrying one payload beat.
`default_nettype none
interface dsc_stream_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/dsc_div.sv */
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module dsc_div #(
    parameter int DEN_W = dsc_pkg::OPERAND_WIDTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dsc_pkg::div_ctl_t        ctl,
    input  wire logic [dsc_pkg::RES_W-1:0] dividend,
    input  wire logic [DEN_W-1:0]         divisor,
    output logic                          done,
    output logic [dsc_pkg::RES_W-1:0]     quotient,
    output logic [DEN_W-1:0]              remainder
);
    localparam int NUM_W = dsc_pkg::RES_W;
    localparam int CW    = $clog2(NUM_W + 1);
    localparam int PRE   = NUM_W - DEN_W;

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            // short operands sit in the low bits: pre-align and run fewer steps
            num_next  = ctl.short_op ? (dividend << PRE) : dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = ctl.short_op ? CW'(DEN_W) : CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], ge};
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

/* rtl/diophantine_solution_counter.sv */
// Top level: sequencer, shared multiplier and serial divider for a*x+b*y=c.
//
// Usage: one beat on req carries a, b, c and inclusive x and y ranges; one
// beat on rsp carries solvable, a particular (x0, y0), gcd(|a|,|b|) and the
// number of solutions inside both ranges (saturating at 2^64-1).
// req.ready is high only while the sequencer is idle; one item is in flight
// at a time. Work per item, W = OPERAND_WIDTH:
//   - n extended-Euclid steps, each a short divide on the shared divider
//     plus control states and two passes through the shared
//     signed multiplier (n is at most about 1.44*W);
//   - one short divide of c by the gcd, two multiplies for x0 and y0;
//   - in the general case four full-width divides for the bounds on k.
// Both-zero and single-zero coefficients take a short path.
// The result sits in an output register; the next item is accepted while
// it waits. If rsp stalls, the finished item holds the sequencer until the
// register frees. Reset clears the sequencer and drops any pending beat.
`default_nettype none
module diophantine_solution_counter #(
    parameter int OPERAND_WIDTH = dsc_pkg::OPERAND_WIDTH
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dsc_stream_if.sink   req,
    dsc_stream_if.source rsp
);
    localparam int W   = OPERAND_WIDTH;
    localparam int SW  = W + 2;
    localparam int PW  = 2 * SW;
    localparam int KW  = dsc_pkg::K_W;
    localparam int RW  = dsc_pkg::RES_W;
    localparam int PXW = dsc_pkg::PROD_MAX_W;
    localparam int FW  = dsc_pkg::FIELD_W;

    function automatic logic signed [SW-1:0] sext(input logic [FW-1:0] v);
        sext = signed'({{(SW-W){v[W-1]}}, v[W-1:0]});
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] m;
        m = (v < 0) ? -v : v;
        mag = m[W-1:0];
    endfunction

    function automatic logic signed [SW-1:0] rsize(input logic signed [SW-1:0] lo,
                                                   input logic signed [SW-1:0] hi);
        rsize = (lo > hi) ? '0 : hi - lo + SW'(1);
    endfunction

    dsc_pkg::state_t state_reg, state_next;

    logic signed [SW-1:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic signed [SW-1:0] xl_reg, xl_next, xu_reg, xu_next;
    logic signed [SW-1:0] yl_reg, yl_next, yu_reg, yu_next;
    logic [W-1:0]         r0_reg, r0_next, r1_reg, r1_next, quo_reg, quo_next;
    logic signed [SW-1:0] s0_reg, s0_next, t0_reg, t0_next;
    logic signed [SW-1:0] s1_reg, s1_next, t1_reg, t1_next;
    logic signed [SW-1:0] cg_reg, cg_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [RW-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic signed [KW-1:0] klo_reg, klo_next, khi_reg, khi_next;
    logic [1:0]           kidx_reg, kidx_next;
    logic [RW-1:0]        cnt_reg, cnt_next;
    logic                 solv_reg, solv_next;
    logic [W-1:0]         g_reg, g_next;
    dsc_pkg::out_item_t   out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic signed [SW-1:0]  in_a, in_b, mul_a, mul_b, sx, sy;
    logic signed [PXW-1:0] prod_wide, prod_neg;
    logic signed [KW-1:0]  dxl, dxu, dyl, dyu, num, num_abs, q_s, q_up, kv;
    logic signed [RW-1:0]  y0_val;
    logic                  a_neg, b_neg, a_zero, b_zero;

    dsc_pkg::div_ctl_t div_ctl;
    logic [RW-1:0]     div_dividend, div_q;
    logic [W-1:0]      div_divisor, div_r;
    logic              div_done;

    dsc_div #(.DEN_W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign in_a   = sext(req.data.a_coef);
    assign in_b   = sext(req.data.b_coef);
    assign a_neg  = a_reg < 0;
    assign b_neg  = b_reg < 0;
    assign a_zero = a_reg == '0;
    assign b_zero = b_reg == '0;
    assign sx     = rsize(xl_reg, xu_reg);
    assign sy     = rsize(yl_reg, yu_reg);

    assign prod_wide = PXW'(prod_reg);
    assign prod_neg  = -prod_wide;

    assign dxl = KW'(xl_reg) - KW'(x0_reg);
    assign dxu = KW'(xu_reg) - KW'(x0_reg);
    assign dyl = KW'(yl_reg) - KW'(y0_reg);
    assign dyu = KW'(yu_reg) - KW'(y0_reg);

    // k bound in progress: 0 and 1 from the x range, 2 and 3 from the y range
    always_comb
    begin
        unique case (kidx_reg)
            2'd0: num = b_neg ? -dxu : dxl;
            2'd1: num = b_neg ? -dxl : dxu;
            2'd2: num = a_neg ? dyl : -dyu;
            2'd3: num = a_neg ? dyu : -dyl;
            default: num = '0;
        endcase
    end

    assign num_abs = (num < 0) ? -num : num;
    assign q_s     = signed'({{(KW-RW){1'b0}}, div_q});
    assign q_up    = q_s + KW'(div_r != '0);
    // even index: ceil of num/m, odd index: floor
    assign kv = kidx_reg[0] ? ((num < 0) ? -q_up : q_s)
                            : ((num > 0) ? q_up : -q_s);
    assign y0_val = RW'(b_neg ? prod_neg : prod_wide);

    always_comb
    begin
        state_next     = state_reg;
        a_next = a_reg;   b_next = b_reg;   c_next = c_reg;
        xl_next = xl_reg; xu_next = xu_reg; yl_next = yl_reg; yu_next = yu_reg;
        r0_next = r0_reg; r1_next = r1_reg; quo_next = quo_reg;
        s0_next = s0_reg; t0_next = t0_reg; s1_next = s1_reg; t1_next = t1_reg;
        cg_next = cg_reg; x0_next = x0_reg; y0_next = y0_reg;
        klo_next = klo_reg; khi_next = khi_reg; kidx_next = kidx_reg;
        cnt_next = cnt_reg; solv_next = solv_reg; g_next = g_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~rsp.ready;
        div_ctl        = '0;
        div_dividend   = RW'(r0_reg);
        div_divisor    = r1_reg;
        mul_a          = '0;
        mul_b          = '0;

        unique case (state_reg)
            dsc_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    a_next  = in_a;
                    b_next  = in_b;
                    c_next  = sext(req.data.c_rhs);
                    xl_next = sext(req.data.x_lower);
                    xu_next = sext(req.data.x_upper);
                    yl_next = sext(req.data.y_lower);
                    yu_next = sext(req.data.y_upper);
                    r0_next = mag(in_b);
                    r1_next = mag(in_a);
                    s0_next = '0;
                    t0_next = SW'(1);
                    s1_next = SW'(1);
                    t1_next = '0;
                    x0_next = '0;
                    y0_next = '0;
                    cnt_next  = '0;
                    solv_next = 1'b0;
                    g_next    = '0;
                    state_next = (in_a == '0 && in_b == '0) ? dsc_pkg::S_ZMUL
                                                            : dsc_pkg::S_EUC;
                end
            end
            dsc_pkg::S_ZMUL:
            begin
                mul_a = sx;
                mul_b = sy;
                state_next = (c_reg == '0) ? dsc_pkg::S_ZSAT : dsc_pkg::S_OUT;
            end
            dsc_pkg::S_ZSAT:
            begin
                solv_next  = 1'b1;
                cnt_next   = (|prod_wide[PXW-1:RW]) ? '1 : prod_wide[RW-1:0];
                state_next = dsc_pkg::S_OUT;
            end
            dsc_pkg::S_EUC:
            begin
                if (r1_reg == '0)
                begin
                    g_next     = r0_reg;
                    state_next = dsc_pkg::S_CDIV;
                end
                else
                begin
                    div_ctl.start    = 1'b1;
                    div_ctl.short_op = 1'b1;
                    state_next       = dsc_pkg::S_EUC_WAIT;
                end
            end
            dsc_pkg::S_EUC_WAIT:
            begin
                if (div_done)
                begin
                    quo_next   = div_q[W-1:0];
                    r0_next    = r1_reg;
                    r1_next    = div_r;
                    state_next = dsc_pkg::S_EUC_MS;
                end
            end
            dsc_pkg::S_EUC_MS:
            begin
                mul_a = signed'({2'b00, quo_reg});
                mul_b = s1_reg;
                state_next = dsc_pkg::S_EUC_US;
            end
            dsc_pkg::S_EUC_US:
            begin
                s0_next = s1_reg;
                s1_next = SW'(s0_reg - prod_reg);
                mul_a = signed'({2'b00, quo_reg});
                mul_b = t1_reg;
                state_next = dsc_pkg::S_EUC_UT;
            end
            dsc_pkg::S_EUC_UT:
            begin
                t0_next    = t1_reg;
                t1_next    = SW'(t0_reg - prod_reg);
                state_next = dsc_pkg::S_EUC;
            end
            dsc_pkg::S_CDIV:
            begin
                div_ctl.start    = 1'b1;
                div_ctl.short_op = 1'b1;
                div_dividend     = RW'(mag(c_reg));
                div_divisor      = g_reg;
                state_next       = dsc_pkg::S_CDIV_WAIT;
            end
            dsc_pkg::S_CDIV_WAIT:
            begin
                if (div_done)
                begin
                    if (div_r != '0)
                    begin
                        state_next = dsc_pkg::S_OUT;
                    end
                    else
                    begin
                        solv_next  = 1'b1;
                        cg_next    = (c_reg < 0) ? -signed'({2'b00, div_q[W-1:0]})
                                                 : signed'({2'b00, div_q[W-1:0]});
                        state_next = dsc_pkg::S_X0M;
                    end
                end
            end
            dsc_pkg::S_X0M:
            begin
                mul_a = s0_reg;
                mul_b = cg_reg;
                state_next = dsc_pkg::S_X0;
            end
            dsc_pkg::S_X0:
            begin
                x0_next = RW'(a_neg ? prod_neg : prod_wide);
                mul_a = t0_reg;
                mul_b = cg_reg;
                state_next = dsc_pkg::S_Y0;
            end
            dsc_pkg::S_Y0:
            begin
                y0_next = y0_val;
                if (a_zero)
                begin
                    // y is fixed at c/b; x runs free over its range
                    cnt_next = (y0_val >= RW'(yl_reg) && y0_val <= RW'(yu_reg))
                               ? RW'(sx) : '0;
                    state_next = dsc_pkg::S_OUT;
                end
                else if (b_zero)
                begin
                    cnt_next = (x0_reg >= RW'(xl_reg) && x0_reg <= RW'(xu_reg))
                               ? RW'(sy) : '0;
                    state_next = dsc_pkg::S_OUT;
                end
                else
                begin
                    kidx_next  = '0;
                    state_next = dsc_pkg::S_K;
                end
            end
            dsc_pkg::S_K:
            begin
                // |s1| = |b|/g and |t1| = |a|/g once Euclid has run out
                div_ctl.start = 1'b1;
                div_dividend  = num_abs[RW-1:0];
                div_divisor   = kidx_reg[1] ? mag(t1_reg) : mag(s1_reg);
                state_next    = dsc_pkg::S_K_WAIT;
            end
            dsc_pkg::S_K_WAIT:
            begin
                if (div_done)
                begin
                    unique case (kidx_reg)
                        2'd0: klo_next = kv;
                        2'd1: khi_next = kv;
                        2'd2: klo_next = (kv > klo_reg) ? kv : klo_reg;
                        2'd3: khi_next = (kv < khi_reg) ? kv : khi_reg;
                        default: klo_next = klo_reg;
                    endcase
                    kidx_next  = kidx_reg + 2'd1;
                    state_next = (&kidx_reg) ? dsc_pkg::S_KCNT : dsc_pkg::S_K;
                end
            end
            dsc_pkg::S_KCNT:
            begin
                cnt_next   = (klo_reg > khi_reg) ? '0 : RW'(khi_reg - klo_reg + KW'(1));
                state_next = dsc_pkg::S_OUT;
            end
            dsc_pkg::S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next.solvable       = solv_reg;
                    out_next.x_particular   = x0_reg;
                    out_next.y_particular   = y0_reg;
                    out_next.gcd_value      = FW'(g_reg);
                    out_next.solution_count = cnt_reg;
                    out_valid_next          = 1'b1;
                    state_next              = dsc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dsc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            kidx_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            kidx_reg      <= kidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;   b_reg <= b_next;   c_reg <= c_next;
        xl_reg <= xl_next; xu_reg <= xu_next; yl_reg <= yl_next; yu_reg <= yu_next;
        r0_reg <= r0_next; r1_reg <= r1_next; quo_reg <= quo_next;
        s0_reg <= s0_next; t0_reg <= t0_next; s1_reg <= s1_next; t1_reg <= t1_next;
        cg_reg <= cg_next; x0_reg <= x0_next; y0_reg <= y0_next;
        klo_reg <= klo_next; khi_reg <= khi_next;
        cnt_reg <= cnt_next; solv_reg <= solv_next; g_reg <= g_next;
        out_reg <= out_next;
        prod_reg <= mul_a * mul_b;
    end

    assign req.ready = state_reg == dsc_pkg::S_IDLE;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;
endmodule
`default_nettype wire

/* tb/dsc_checker.sv */
// Checker for the Diophantine solution counter: watches both channels, predicts, compares.
`timescale 1ns / 100ps
`default_nettype none
module dsc_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_ready,
    input  wire dsc_pkg::in_item_t  req_data,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_ready,
    input  wire dsc_pkg::out_item_t rsp_data,
    output int                     fail_count,
    output int                     pending_count
);

    dsc_pkg::out_item_t solution_queue[$];

    function automatic longint fdiv(longint n, longint d);
        longint q;
        longint r;
        q = n / d;
        r = n % d;
        if (r != 0 && ((r < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic longint cdiv(longint n, longint d);
        return -fdiv(-n, d);
    endfunction

    function automatic longint unsigned span(longint lo, longint hi);
        if (lo > hi)
            return 0;
        return longint'(hi - lo) + 1;
    endfunction

    function automatic dsc_pkg::out_item_t solve_item(dsc_pkg::in_item_t it);
        dsc_pkg::out_item_t r;
        longint a, b, c, xl, xu, yl, yu, p, q, rem, s, t, nx, x0, y0, g;
        longint ar, br, k1lo, k1hi, k2lo, k2hi, lo, hi, d;
        longint quo[$];
        longint unsigned sx, sy, cnt;
        a = it.a_coef; b = it.b_coef; c = it.c_rhs;
        xl = it.x_lower; xu = it.x_upper; yl = it.y_lower; yu = it.y_upper;
        g = 0; x0 = 0; y0 = 0; cnt = 0;
        r = '0;
        if (a == 0 && b == 0) begin
            if (c == 0) begin
                r.solvable = 1'b1;
                sx = span(xl, xu);
                sy = span(yl, yu);
                if (sx != 0 && sy > 64'hFFFF_FFFF_FFFF_FFFF / sx)
                    cnt = 64'hFFFF_FFFF_FFFF_FFFF;
                else
                    cnt = sx * sy;
            end
        end
        else begin
            p = (a < 0) ? -a : a;
            q = (b < 0) ? -b : b;
            while (p != 0) begin
                rem = q % p;
                quo.push_back(q / p);
                q = p;
                p = rem;
            end
            s = 0; t = 1;
            while (quo.size() > 0) begin
                nx = t - quo.pop_back() * s;
                t = s;
                s = nx;
            end
            g = q;
            if (c % g == 0) begin
                r.solvable = 1'b1;
                x0 = s * (c / g);
                y0 = t * (c / g);
                if (a < 0) x0 = -x0;
                if (b < 0) y0 = -y0;
                if (a == 0) begin
                    if (c / b >= yl && c / b <= yu) cnt = span(xl, xu);
                end
                else if (b == 0) begin
                    if (c / a >= xl && c / a <= xu) cnt = span(yl, yu);
                end
                else begin
                    ar = a / g;
                    br = b / g;
                    lo = xl - x0; hi = xu - x0; d = br;
                    if (d > 0) begin k1lo = cdiv(lo, d); k1hi = fdiv(hi, d); end
                    else begin k1lo = cdiv(hi, d); k1hi = fdiv(lo, d); end
                    lo = yl - y0; hi = yu - y0; d = -ar;
                    if (d > 0) begin k2lo = cdiv(lo, d); k2hi = fdiv(hi, d); end
                    else begin k2lo = cdiv(hi, d); k2hi = fdiv(lo, d); end
                    if (k2lo > k1lo) k1lo = k2lo;
                    if (k2hi < k1hi) k1hi = k2hi;
                    cnt = span(k1lo, k1hi);
                end
            end
            else begin
                x0 = 0;
                y0 = 0;
            end
        end
        r.x_particular   = x0;
        r.y_particular   = y0;
        r.gcd_value      = g[31:0];
        r.solution_count = cnt;
        return r;
    endfunction

    assign pending_count = solution_queue.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        dsc_pkg::out_item_t want;
        if (rst_n) begin
            if (req_valid && req_ready)
                solution_queue.push_back(solve_item(req_data));
            if (rsp_valid && rsp_ready) begin
                if (solution_queue.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result beat %p", rsp_data);
                end
                else begin
                    want = solution_queue.pop_front();
                    if (want.solvable !== rsp_data.solvable
                        || want.x_particular !== rsp_data.x_particular
                        || want.y_particular !== rsp_data.y_particular
                        || want.gcd_value !== rsp_data.gcd_value
                        || want.solution_count !== rsp_data.solution_count) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected solv=%0d x0=%0d y0=%0d g=%0d n=%0d, got solv=%0d x0=%0d y0=%0d g=%0d n=%0d",
                                want.solvable, want.x_particular, want.y_particular,
                                want.gcd_value, want.solution_count,
                                rsp_data.solvable, rsp_data.x_particular,
                                rsp_data.y_particular, rsp_data.gcd_value,
                                rsp_data.solution_count);
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

/* tb/diophantine_solution_counter_tb.sv */
// Stimulus and verdict for the Diophantine solution counter.
`timescale 1ns / 100ps
`default_nettype none
module diophantine_solution_counter_tb;

    localparam int RANDOM_ITEMS = 1500;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off_cycles;

    dsc_stream_if #(.item_t(dsc_pkg::in_item_t))  req ();
    dsc_stream_if #(.item_t(dsc_pkg::out_item_t)) rsp ();

    diophantine_solution_counter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    dsc_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_ready     (req.ready),
        .req_data      (req.data),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .rsp_data      (rsp.data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #200_000_000;
        $display("diophantine_solution_counter test failed");
        $finish;
    end

    // Receiver: random stalls, or a long counted hold-off when asked.
    initial rsp.ready = 1'b0;
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [31:0] pick_value(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(40) - 20;
            2: return 32'h8000_0000 + $urandom_range(3);
            3: return 32'h7FFF_FFFF - $urandom_range(3);
            default: return $urandom_range(2000) - 1000;
        endcase
    endfunction

    function automatic dsc_pkg::in_item_t random_item();
        dsc_pkg::in_item_t it;
        int m;
        m = $urandom_range(9);
        it.a_coef  = (m == 0) ? 32'sd0 : pick_value($urandom_range(4));
        it.b_coef  = (m == 1) ? 32'sd0 : pick_value($urandom_range(4));
        it.c_rhs   = pick_value($urandom_range(4));
        if (m == 2) begin
            it.a_coef = 0;
            it.b_coef = 0;
            if ($urandom_range(1)) it.c_rhs = 0;
        end
        it.x_lower = pick_value($urandom_range(4));
        it.x_upper = ($urandom_range(3) == 0) ? pick_value($urandom_range(4))
                     : it.x_lower + $urandom_range(100000);
        if ($signed(it.x_upper) < $signed(it.x_lower) && $urandom_range(3) != 0)
            it.x_upper = 32'h7FFF_FFFF;
        it.y_lower = pick_value($urandom_range(4));
        it.y_upper = ($urandom_range(3) == 0) ? pick_value($urandom_range(4))
                     : it.y_lower + $urandom_range(100000);
        if ($signed(it.y_upper) < $signed(it.y_lower) && $urandom_range(3) != 0)
            it.y_upper = 32'h7FFF_FFFF;
        return it;
    endfunction

    // Leave valid high after the beat; the next beat or drain decides what follows.
    task automatic send_beat(dsc_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= it;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic directed_item(int a, int b, int c, int xl, int xu, int yl, int yu);
        dsc_pkg::in_item_t it;
        it = '{a, b, c, xl, xu, yl, yu};
        send_beat(it);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    localparam int MIN_I = 32'h8000_0000;
    localparam int MAX_I = 32'h7FFF_FFFF;

    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_item(0, 0, 0, MIN_I, MAX_I, MIN_I, MAX_I);
        directed_item(0, 0, 0, -3, 4, 10, 12);
        directed_item(0, 0, 5, -3, 4, 10, 12);
        directed_item(0, 0, 0, 5, 4, 0, 1);
        directed_item(0, 7, 21, -5, 5, 0, 5);
        directed_item(0, 7, 20, -5, 5, 0, 5);
        directed_item(-6, 0, 18, -5, 5, MIN_I, MAX_I);
        directed_item(4, 6, 7, -100, 100, -100, 100);
        directed_item(4, 6, 10, -100, 100, -100, 100);
        directed_item(-4, 6, -10, -100, 100, -100, 100);
        directed_item(3, -5, 1, MIN_I, MAX_I, MIN_I, MAX_I);
        directed_item(MIN_I, MIN_I, MIN_I, MIN_I, MAX_I, MIN_I, MAX_I);
        directed_item(MIN_I, MAX_I, MAX_I, MIN_I, MAX_I, MIN_I, MAX_I);
        directed_item(MAX_I, MAX_I - 1, MIN_I, MIN_I, MAX_I, MIN_I, MAX_I);
        directed_item(MIN_I, 0, MIN_I, 1, 1, 0, 0);
        directed_item(1, 1, 0, 10, 0, -5, 5);
        directed_item(1, 1, 0, -5, 5, 10, 0);
        directed_item(-1, -1, -1, -1, -1, -1, -1);
        directed_item(1836311903, 1134903170, 1, MIN_I, MAX_I, MIN_I, MAX_I);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            if (phase == 0)
                hold_off_cycles = 6000;
            for (int i = 0; i < RANDOM_ITEMS / 4; i++)
                send_beat(random_item());
            drain();
        end

        repeat (3000) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("diophantine_solution_counter test passed");
        else
            $display("diophantine_solution_counter test failed");
        $finish;
    end

endmodule
`default_nettype wire
